>>> rtl/gmns_pkg.sv
// Package for the grid map nearest marked search block.
// Holds grid geometry, derived widths, item kind codes and the shared struct types.
// No dependencies.
package gmns_pkg;

  // Grid geometry.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 32;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

  // Derived widths: cell address, in-grid indexes and walk counters.
  localparam int ADDR_W    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_IDX_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int ROW_IDX_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int COL_CNT_W = $clog2(GRID_WIDTH + 1);
  localparam int ROW_CNT_W = $clog2(GRID_HEIGHT + 1);

  // Signed coordinates cover start -/+ offset for 8-bit starts and offsets.
  localparam int COORD_W = 10;
  localparam int CELL_W  = 8;

  localparam logic [7:0] NONE_COORD = 8'd255;

  // Item kind codes.
  localparam logic [2:0] KIND_WRITE   = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_FILL    = 3'd2;
  localparam logic [2:0] KIND_NEAREST = 3'd3;
  localparam logic [2:0] KIND_RASTER  = 3'd4;

  // Input item.
  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        pos_x;
    logic [7:0]        pos_y;
    logic [CELL_W-1:0] cell_value;
  } gmns_in_t;

  // Result item.
  typedef struct packed {
    logic              found;
    logic [7:0]        out_x;
    logic [7:0]        out_y;
    logic [CELL_W-1:0] read_data;
  } gmns_out_t;

  // Control from the sequencer to the nearest-search walk.
  typedef struct packed {
    logic init;
    logic step;
  } walk_ctrl_t;

  // Status from the walk: current candidate and its qualifiers.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               row_ok;
    logic               last;
  } walk_stat_t;

endpackage

>>> rtl/gmns_ram.sv
// Generic single-port RAM with registered read data.
// Width and depth are parameters; no other dependencies.
module gmns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read of the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/gmns_addr_unit.sv
// Shared address unit: grid bounds check and row-major cell address.
// Depends on gmns_pkg.
module gmns_addr_unit (
  input  logic [gmns_pkg::COORD_W-1:0] x,
  input  logic [gmns_pkg::COORD_W-1:0] y,
  output logic                         on_grid,
  output logic [gmns_pkg::ADDR_W-1:0]  addr
);
  import gmns_pkg::*;

  localparam logic signed [COORD_W-1:0] W_C = COORD_W'(GRID_WIDTH);
  localparam logic signed [COORD_W-1:0] H_C = COORD_W'(GRID_HEIGHT);

  // Both coordinates must be non-negative and below the grid size.
  assign on_grid = !x[COORD_W-1] && ($signed(x) < W_C) &&
                   !y[COORD_W-1] && ($signed(y) < H_C);

  // Row times width plus column; only meaningful when on the grid.
  assign addr = ADDR_W'(32'(y[ROW_IDX_W-1:0]) * 32'(GRID_WIDTH)) +
                ADDR_W'(x[COL_IDX_W-1:0]);

endmodule

>>> rtl/gmns_near_walk.sv
// Candidate walk for the nearest search: rows start, start-d, start+d, and
// within each row columns start-e, start+e. Depends on gmns_pkg.
module gmns_near_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  gmns_pkg::walk_ctrl_t ctrl,
  input  logic [7:0]          sx,
  input  logic [7:0]          sy,
  output gmns_pkg::walk_stat_t stat
);
  import gmns_pkg::*;

  localparam logic signed [COORD_W-1:0] W_C = COORD_W'(GRID_WIDTH);
  localparam logic signed [COORD_W-1:0] H_C = COORD_W'(GRID_HEIGHT);

  logic [ROW_CNT_W-1:0] d_r, d_nxt;
  logic [COL_CNT_W-1:0] e_r, e_nxt;
  logic                 rside_r, rside_nxt;
  logic                 cside_r, cside_nxt;

  logic signed [COORD_W-1:0] sx_c, sy_c, d_c, e_c, e_inc_c;
  logic signed [COORD_W-1:0] row_c, col_c, lo_inc, hi_inc;
  logic [COL_CNT_W-1:0]      e_inc;
  logic [ROW_CNT_W-1:0]      d_inc;
  logic                      row_ok, col_wrap, col_end, row_adv, row_wrap, row_end;

  // Current candidate from the offsets and the side flags.
  always_comb begin
    sx_c    = COORD_W'(sx);
    sy_c    = COORD_W'(sy);
    d_c     = COORD_W'(d_r);
    e_c     = COORD_W'(e_r);
    e_inc   = e_r + COL_CNT_W'(1);
    d_inc   = d_r + ROW_CNT_W'(1);
    e_inc_c = COORD_W'(e_inc);
    row_c   = rside_r ? (sy_c + d_c) : (sy_c - d_c);
    col_c   = cside_r ? (sx_c + e_c) : (sx_c - e_c);
    lo_inc  = sx_c - e_inc_c;
    hi_inc  = sx_c + e_inc_c;
    row_ok  = !row_c[COORD_W-1] && (row_c < H_C);
  end

  // A row ends when it is off the grid, the offset runs out or both sides have left the grid.
  always_comb begin
    col_wrap = cside_r || (e_r == '0);
    col_end  = col_wrap && ((e_inc == COL_CNT_W'(GRID_WIDTH)) ||
                            (lo_inc[COORD_W-1] && !(hi_inc < W_C)));
    row_adv  = !row_ok || col_end;
    row_wrap = rside_r || (d_r == '0);
    row_end  = row_wrap && (d_inc == ROW_CNT_W'(GRID_HEIGHT));
  end

  // Advance to the next candidate on each step.
  always_comb begin
    d_nxt     = d_r;
    e_nxt     = e_r;
    rside_nxt = rside_r;
    cside_nxt = cside_r;
    if (ctrl.init) begin
      d_nxt     = '0;
      e_nxt     = '0;
      rside_nxt = 1'b0;
      cside_nxt = 1'b0;
    end else if (ctrl.step) begin
      if (row_adv) begin
        e_nxt     = '0;
        cside_nxt = 1'b0;
        if (row_wrap) begin
          d_nxt     = d_inc;
          rside_nxt = 1'b0;
        end else begin
          rside_nxt = 1'b1;
        end
      end else if (col_wrap) begin
        e_nxt     = e_inc;
        cside_nxt = 1'b0;
      end else begin
        cside_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r     <= '0;
      e_r     <= '0;
      rside_r <= 1'b0;
      cside_r <= 1'b0;
    end else begin
      d_r     <= d_nxt;
      e_r     <= e_nxt;
      rside_r <= rside_nxt;
      cside_r <= cside_nxt;
    end
  end

  assign stat.col    = col_c;
  assign stat.row    = row_c;
  assign stat.row_ok = row_ok;
  assign stat.last   = row_adv && row_end;

endmodule

>>> rtl/grid_map_nearest_marked_search_top.sv
// Top level of the grid map nearest marked search block: sequencer, result register.
// Depends on gmns_pkg, gmns_ram, gmns_addr_unit and gmns_near_walk.
//
//  Channel  | Ports                 | Transfer
//  ---------+-----------------------+-----------------------------------------
//  input    | start, busy, in_item  | at a clock edge with start high, busy low
//  result   | out_valid, out_item   | one cycle strobe, taken at its closing edge
//
// A nearest search issues the candidates of the walk in order, at most about
// 4 * GRID_WIDTH * GRID_HEIGHT of them; a raster scan first folds a start column
// past the row end into later rows, then scans the cells in row-major order.
// Both searches are set by the single memory read port, one cell per cycle.
// After reset a clearing pass over every cell runs with busy high.
// The result side cannot stall: each result is a single-cycle strobe.
module grid_map_nearest_marked_search_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gmns_pkg::gmns_in_t  in_item,
  output logic               out_valid,
  output gmns_pkg::gmns_out_t out_item
);
  import gmns_pkg::*;

  localparam logic signed [COORD_W-1:0] W_C = COORD_W'(GRID_WIDTH);
  localparam logic signed [COORD_W-1:0] H_C = COORD_W'(GRID_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DISP  = 9'b000000100,
    S_FILL  = 9'b000001000,
    S_READ  = 9'b000010000,
    S_NEAR  = 9'b000100000,
    S_NORM  = 9'b001000000,
    S_RAST  = 9'b010000000,
    S_DRAIN = 9'b100000000
  } state_t;

  state_t                    state_r, state_nxt;
  gmns_in_t                  item_r, item_nxt;
  logic [ADDR_W-1:0]         cnt_r, cnt_nxt;
  logic signed [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  logic [COORD_W-1:0]        pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic                      out_valid_r, out_valid_nxt;
  gmns_out_t                 out_r, out_nxt;

  logic [COORD_W-1:0] ax, ay;
  logic               on_grid;
  logic [ADDR_W-1:0]  cell_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [CELL_W-1:0]  mem_wdata, mem_rdata;
  logic               hit;
  walk_ctrl_t         walk_ctrl;
  walk_stat_t         walk_stat;

  // Shared address unit sees the walk candidate in a nearest search, else the cursor.
  assign ax = (state_r == S_NEAR) ? walk_stat.col : cur_x_r;
  assign ay = (state_r == S_NEAR) ? walk_stat.row : cur_y_r;

  gmns_addr_unit u_addr (
    .x       (ax),
    .y       (ay),
    .on_grid (on_grid),
    .addr    (cell_addr)
  );

  gmns_near_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (walk_ctrl),
    .sx    (item_r.pos_x),
    .sy    (item_r.pos_y),
    .stat  (walk_stat)
  );

  gmns_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // The cell read in the previous cycle is marked.
  assign hit = pend_vld_r && (mem_rdata != '0);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    pend_vld_nxt  = pend_vld_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    walk_ctrl     = '0;
    mem_we        = 1'b0;
    mem_addr      = cell_addr;
    mem_wdata     = item_r.cell_value;

    unique case (state_r)
      // Clearing pass after reset.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = cnt_r;
        mem_wdata = '0;
        cnt_nxt   = cnt_r + ADDR_W'(1);
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          cur_x_nxt = COORD_W'(in_item.pos_x);
          cur_y_nxt = COORD_W'(in_item.pos_y);
          state_nxt = S_DISP;
        end
      end

      // Decode the kind of the accepted item.
      S_DISP: begin
        unique case (item_r.kind)
          KIND_WRITE: begin
            mem_we        = on_grid;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            state_nxt     = S_IDLE;
          end
          KIND_READ: begin
            pend_vld_nxt = on_grid;
            state_nxt    = S_READ;
          end
          KIND_FILL: begin
            cnt_nxt   = '0;
            state_nxt = S_FILL;
          end
          KIND_NEAREST: begin
            walk_ctrl.init = 1'b1;
            pend_vld_nxt   = 1'b0;
            state_nxt      = S_NEAR;
          end
          KIND_RASTER: begin
            pend_vld_nxt = 1'b0;
            state_nxt    = S_NORM;
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      // Sweep every cell with the fill value.
      S_FILL: begin
        mem_we   = 1'b1;
        mem_addr = cnt_r;
        cnt_nxt  = cnt_r + ADDR_W'(1);
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end

      S_READ: begin
        out_valid_nxt     = 1'b1;
        out_nxt           = '0;
        out_nxt.read_data = pend_vld_r ? mem_rdata : '0;
        state_nxt         = S_IDLE;
      end

      // Issue one walk candidate a cycle and test the one read before it.
      S_NEAR: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found: 1'b1, out_x: pend_x_r[7:0], out_y: pend_y_r[7:0],
                            read_data: '0};
          state_nxt     = S_IDLE;
        end else begin
          walk_ctrl.step = 1'b1;
          pend_vld_nxt   = walk_stat.row_ok && on_grid;
          pend_x_nxt     = walk_stat.col;
          pend_y_nxt     = walk_stat.row;
          if (walk_stat.last) begin
            state_nxt = S_DRAIN;
          end
        end
      end

      // Fold a start column past the row end into later rows.
      S_NORM: begin
        if (!(cur_x_r < W_C)) begin
          cur_x_nxt = cur_x_r - W_C;
          cur_y_nxt = cur_y_r + COORD_W'(1);
        end else begin
          state_nxt = S_RAST;
        end
      end

      // Linear scan, one cell a cycle.
      S_RAST: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found: 1'b1, out_x: pend_x_r[7:0], out_y: pend_y_r[7:0],
                            read_data: '0};
          state_nxt     = S_IDLE;
        end else if (!(cur_y_r < H_C)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found: 1'b0, out_x: NONE_COORD, out_y: NONE_COORD,
                            read_data: '0};
          state_nxt     = S_IDLE;
        end else begin
          pend_vld_nxt = 1'b1;
          pend_x_nxt   = cur_x_r;
          pend_y_nxt   = cur_y_r;
          if (cur_x_r == W_C - COORD_W'(1)) begin
            cur_x_nxt = '0;
            cur_y_nxt = cur_y_r + COORD_W'(1);
          end else begin
            cur_x_nxt = cur_x_r + COORD_W'(1);
          end
        end
      end

      // Test the last candidate of the nearest search.
      S_DRAIN: begin
        out_valid_nxt = 1'b1;
        if (hit) begin
          out_nxt = '{found: 1'b1, out_x: pend_x_r[7:0], out_y: pend_y_r[7:0],
                      read_data: '0};
        end else begin
          out_nxt = '{found: 1'b0, out_x: NONE_COORD, out_y: NONE_COORD,
                      read_data: '0};
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    pend_x_r <= pend_x_nxt;
    pend_y_r <= pend_y_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A result strobe always lands with the sequencer back at rest.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside the idle state");

  // Two results are never strobed in consecutive cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // The grid is written only by the clearing pass, a fill or a single write.
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_FILL || state_r == S_DISP))
    else $error("cell write during a search");

  // A marked cell seen during a search ends it with a result next cycle.
  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_NEAR || state_r == S_RAST) && hit) |=> (out_valid_r && out_r.found))
    else $error("search hit without a found result");

  // A found cell lies on the grid.
  a_found_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |->
      ((out_r.out_x < 8'(GRID_WIDTH)) && (out_r.out_y < 8'(GRID_HEIGHT))))
    else $error("found cell off the grid");

endmodule
